/* sv/omaa_pkg.sv */
// Package for the object motion activity accumulator: widths, codes and state types.
`default_nettype none
package omaa_pkg;
   localparam int TableDepth = 1024;
   localparam int IdxBits    = $clog2(TableDepth);
   localparam int CoordBits  = 12;
   localparam int FracBits   = 8;
   localparam int IdBits     = 10;
   localparam int StepBits   = 21;
   localparam int SumBits    = 48;
   localparam int CntBits    = 32;
   // The radicand is the squared distance shifted up by the fraction bits twice.
   localparam int RootBits   = CoordBits + 1 + FracBits;
   localparam int RadBits    = 2 * RootBits;
   localparam int RemBits    = RootBits + 2;
   localparam int SqBits     = 2 * CoordBits + 1;
   localparam int RootCntBits = $clog2(RootBits + 1);
   localparam int DivCntBits  = $clog2(SumBits + 1);
   // A table entry holds its valid bit above the x and y coordinates.
   localparam int EntryBits   = 2 * CoordBits + 1;

   typedef enum logic [1:0] {
      KIND_REPORT = 2'd0,
      KIND_OBJECT = 2'd1,
      KIND_FRAME  = 2'd2,
      KIND_CLEAR  = 2'd3
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_READ,
      ST_SQX,
      ST_SQY,
      ST_ROOT,
      ST_ACCUM,
      ST_QDIV,
      ST_ADIV,
      ST_DONE
   } state_type;

   // Request to and answer from the shared divider.
   typedef struct packed {
      logic               start;
      logic [SumBits-1:0] dividend;
      logic [CntBits-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [SumBits-1:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

/* sv/object_motion_activity_accumulator.sv */
// Top level of the object motion activity accumulator.
//
// The block takes one transfer at a time on the req_ channel and answers each with exactly one
// transfer on the rsp_ channel. Position reports look up the last centre of their id in a
// 1024-entry RAM whose entries also carry a valid bit; a repeat id has its step distance
// worked out by squaring the coordinate differences on one shared multiplier and taking a
// digit-by-digit square root, and the result is added to the saturating activity total.
// Every transfer then runs the shared shift-subtract divider up to twice, once for objects
// per frame and once for the average. When the quotient is zero the second division is
// skipped, and when the frame total is zero both are skipped. Clear walks all 1024 entries
// to reset their valid bits, one per cycle; the same clearing pass runs after reset, with
// req_stall high throughout. While an item is at work req_stall stays high; a finished
// result is held on the rsp_ ports until it is taken.
`default_nettype none
module object_motion_activity_accumulator import omaa_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [1:0]           req_kind,
   input  wire logic [IdBits-1:0]    req_object_id,
   input  wire logic [CoordBits-1:0] req_pos_x,
   input  wire logic [CoordBits-1:0] req_pos_y,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [StepBits-1:0]       rsp_step_distance,
   output logic                      rsp_first_sighting,
   output logic [SumBits-1:0]        rsp_activity_total,
   output logic [CntBits-1:0]        rsp_object_total,
   output logic [CntBits-1:0]        rsp_frame_total,
   output logic [SumBits-1:0]        rsp_average_activity,
   output logic                      rsp_average_valid
);
   state_type state_ff, state_in;

   // Latched request.
   kind_type              kind_ff, kind_in;
   logic [IdxBits-1:0]    idx_ff, idx_in;
   logic [CoordBits-1:0]  cx_ff, cx_in, cy_ff, cy_in;

   // Totals.
   logic [SumBits-1:0]    sum_ff, sum_in;
   logic [CntBits-1:0]    obj_ff, obj_in, frm_ff, frm_in;

   // Address of the clearing pass.
   logic [IdxBits-1:0]    clr_ff, clr_in;

   // Working registers.
   logic [SqBits-1:0]      d2_ff, d2_in;
   logic [RadBits-1:0]     rad_ff, rad_in;
   logic [RemBits-1:0]     rem_ff, rem_in;
   logic [RootBits-1:0]    root_ff, root_in;
   logic [RootCntBits-1:0] rcnt_ff, rcnt_in;
   logic [StepBits-1:0]    step_ff, step_in;
   logic                   first_ff, first_in;
   logic [SumBits-1:0]     avg_ff, avg_in;
   logic                   avgv_ff, avgv_in;
   logic                   div_sent_ff, div_sent_in;

   // RAM port.
   logic                  ram_we;
   logic [IdxBits-1:0]    ram_addr;
   logic [EntryBits-1:0]  ram_wd;
   logic [EntryBits-1:0]  ram_rd;

   // Shared multiplier operand and the digit step of the square root.
   logic [CoordBits-1:0]  mul_op;
   logic [2*CoordBits-1:0] mul_res;
   logic [RemBits-1:0]    rem_sh, trial;
   logic [SumBits:0]      sum_wide;

   div_req_type div_req;
   div_rsp_type div_rsp;

   // The clearing pass writes empty entries; otherwise the latched request is stored as valid.
   assign ram_addr = (state_ff == ST_CLEAR) ? clr_ff : idx_ff;
   assign ram_wd   = (state_ff == ST_CLEAR) ? '0 : {1'b1, cx_ff, cy_ff};

   omaa_ram #(.Width(EntryBits), .Depth(TableDepth)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (ram_wd),
      .rd_data (ram_rd)
   );

   omaa_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // Absolute difference of the coordinate under work, squared.
   always_comb begin
      logic [CoordBits-1:0] old_c, new_c;
      old_c = (state_ff == ST_SQX) ? ram_rd[2*CoordBits-1:CoordBits] : ram_rd[CoordBits-1:0];
      new_c = (state_ff == ST_SQX) ? cx_ff : cy_ff;
      mul_op = (new_c >= old_c) ? (new_c - old_c) : (old_c - new_c);
      mul_res = mul_op * mul_op;
   end

   assign rem_sh   = {rem_ff[RemBits-3:0], rad_ff[RadBits-1 -: 2]};
   assign trial    = {root_ff[RemBits-3:0], 2'b01};
   assign sum_wide = {1'b0, sum_ff} + {{(SumBits+1-StepBits){1'b0}}, step_ff};

   always_comb begin
      state_in    = state_ff;
      kind_in     = kind_ff;
      idx_in      = idx_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      sum_in      = sum_ff;
      obj_in      = obj_ff;
      frm_in      = frm_ff;
      clr_in      = clr_ff;
      d2_in       = d2_ff;
      rad_in      = rad_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      rcnt_in     = rcnt_ff;
      step_in     = step_ff;
      first_in    = first_ff;
      avg_in      = avg_ff;
      avgv_in     = avgv_ff;
      div_sent_in = div_sent_ff;
      ram_we      = 1'b0;
      div_req     = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = kind_type'(req_kind);
               idx_in   = req_object_id[IdxBits-1:0];
               cx_in    = req_pos_x;
               cy_in    = req_pos_y;
               step_in  = '0;
               first_in = 1'b0;
               avg_in   = '0;
               avgv_in  = 1'b0;
               div_sent_in = 1'b0;
               unique case (kind_type'(req_kind))
                  KIND_REPORT: state_in = ST_READ;
                  KIND_OBJECT: begin
                     if (obj_ff != '1) obj_in = obj_ff + 1'b1;
                     state_in = ST_QDIV;
                  end
                  KIND_FRAME: begin
                     if (frm_ff != '1) frm_in = frm_ff + 1'b1;
                     state_in = ST_QDIV;
                  end
                  KIND_CLEAR: begin
                     sum_in  = '0;
                     obj_in  = '0;
                     frm_in  = '0;
                     clr_in  = '0;
                     state_in = ST_CLEAR;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_CLEAR: begin
            // One entry per cycle; after reset the pass returns to idle, after a clear
            // command it goes on to report the cleared totals.
            ram_we = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) state_in = (kind_ff == KIND_CLEAR) ? ST_QDIV : ST_IDLE;
         end
         ST_READ: begin
            // RAM read is launched this cycle; the entry is seen in the next.
            state_in = ST_SQX;
         end
         ST_SQX: begin
            if (!ram_rd[EntryBits-1]) begin
               first_in = 1'b1;
               ram_we   = 1'b1;
               state_in = ST_QDIV;
            end else begin
               d2_in    = SqBits'(mul_res);
               state_in = ST_SQY;
            end
         end
         ST_SQY: begin
            rad_in  = {1'b0, SqBits'(d2_ff + SqBits'(mul_res)), {(2*FracBits){1'b0}}};
            rem_in  = '0;
            root_in = '0;
            rcnt_in = RootCntBits'(RootBits);
            ram_we  = 1'b1;
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            rad_in = {rad_ff[RadBits-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[RootBits-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[RootBits-2:0], 1'b0};
            end
            rcnt_in = rcnt_ff - 1'b1;
            if (rcnt_ff == RootCntBits'(1)) state_in = ST_ACCUM;
         end
         ST_ACCUM: begin
            step_in  = StepBits'(root_ff);
            state_in = ST_QDIV;
         end
         ST_QDIV: begin
            if (kind_ff == KIND_REPORT && !first_ff && !div_sent_ff) begin
               // Saturating add of the step just finished.
               sum_in = sum_wide[SumBits] ? '1 : sum_wide[SumBits-1:0];
            end
            if (frm_ff == '0) begin
               state_in = ST_DONE;
            end else if (!div_sent_ff) begin
               div_req.start    = 1'b1;
               div_req.dividend = SumBits'(obj_ff);
               div_req.divisor  = frm_ff;
               div_sent_in      = 1'b1;
            end else if (div_rsp.done) begin
               div_sent_in = 1'b0;
               if (div_rsp.quotient == '0) begin
                  state_in = ST_DONE;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = sum_ff;
                  div_req.divisor  = div_rsp.quotient[CntBits-1:0];
                  div_sent_in      = 1'b1;
                  state_in         = ST_ADIV;
               end
            end
         end
         ST_ADIV: begin
            if (div_rsp.done) begin
               avg_in   = div_rsp.quotient;
               avgv_in  = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         kind_ff     <= KIND_REPORT;
         clr_ff      <= '0;
         sum_ff      <= '0;
         obj_ff      <= '0;
         frm_ff      <= '0;
         div_sent_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         kind_ff     <= kind_in;
         clr_ff      <= clr_in;
         sum_ff      <= sum_in;
         obj_ff      <= obj_in;
         frm_ff      <= frm_in;
         div_sent_ff <= div_sent_in;
      end
      idx_ff   <= idx_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      d2_ff    <= d2_in;
      rad_ff   <= rad_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      rcnt_ff  <= rcnt_in;
      step_ff  <= step_in;
      first_ff <= first_in;
      avg_ff   <= avg_in;
      avgv_ff  <= avgv_in;
   end

   assign req_stall            = (state_ff != ST_IDLE);
   assign rsp_valid            = (state_ff == ST_DONE);
   assign rsp_step_distance    = step_ff;
   assign rsp_first_sighting   = first_ff;
   assign rsp_activity_total   = sum_ff;
   assign rsp_object_total     = obj_ff;
   assign rsp_frame_total      = frm_ff;
   assign rsp_average_activity = avg_ff;
   assign rsp_average_valid    = avgv_ff;

   // A result is never offered while a new request can be taken.
   assert property (@(posedge clock) disable iff (reset) !(rsp_valid && !req_stall))
      else $error("result offered while idle");

   // A valid average needs a non-zero frame total.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_average_valid |-> rsp_frame_total != '0)
      else $error("average valid with no frames");

   // A first sighting never carries a distance.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_first_sighting |-> rsp_step_distance == '0)
      else $error("distance on first sighting");

   // Totals never move while a result waits.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_activity_total) && $stable(rsp_object_total))
      else $error("totals changed under a held result");
endmodule
`default_nettype wire

/* sv/omaa_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module omaa_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic [Width-1:0]              rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire

/* sv/omaa_div.sv */
// Restoring shift-subtract divider, one quotient bit per cycle.
`default_nettype none
module omaa_div import omaa_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output div_rsp_type      rsp
);
   logic [SumBits-1:0]    quo_ff, quo_in;
   logic [CntBits:0]      rem_ff, rem_in;
   logic [CntBits-1:0]    dvs_ff, dvs_in;
   logic [DivCntBits-1:0] cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CntBits:0]      trial;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[CntBits-1:0], quo_ff[SumBits-1]};
      if (req.start) begin
         quo_in  = req.dividend;
         rem_in  = '0;
         dvs_in  = req.divisor;
         cnt_in  = DivCntBits'(SumBits);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = trial - {1'b0, dvs_ff};
            quo_in = {quo_ff[SumBits-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[SumBits-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DivCntBits'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = quo_ff;
endmodule
`default_nettype wire

/* test/object_motion_activity_accumulator_tb.sv */
// Self-checking testbench for the object motion activity accumulator.
`default_nettype none
module object_motion_activity_accumulator_tb;
   import omaa_pkg::*;

   // Mask for the 48-bit activity total, which saturates there.
   localparam logic [SumBits-1:0] SumMax = {SumBits{1'b1}};
   localparam logic [CntBits-1:0] CntMax = {CntBits{1'b1}};
   // No transfer for this many cycles means the block has hung.
   localparam int WatchdogLimit = 20000;

   typedef struct packed {
      kind_type              kind;
      logic [IdBits-1:0]     object_id;
      logic [CoordBits-1:0]  pos_x;
      logic [CoordBits-1:0]  pos_y;
   } report_type;

   typedef struct packed {
      logic [StepBits-1:0] step_distance;
      logic                first_sighting;
      logic [SumBits-1:0]  activity_total;
      logic [CntBits-1:0]  object_total;
      logic [CntBits-1:0]  frame_total;
      logic [SumBits-1:0]  average_activity;
      logic                average_valid;
   } summary_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_kind = '0;
   logic [IdBits-1:0] req_object_id = '0;
   logic [CoordBits-1:0] req_pos_x = '0;
   logic [CoordBits-1:0] req_pos_y = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   logic [StepBits-1:0] rsp_step_distance;
   logic rsp_first_sighting;
   logic [SumBits-1:0] rsp_activity_total;
   logic [CntBits-1:0] rsp_object_total;
   logic [CntBits-1:0] rsp_frame_total;
   logic [SumBits-1:0] rsp_average_activity;
   logic rsp_average_valid;

   object_motion_activity_accumulator u_dut (.*);

   // The predictor keeps its own copy of the position table and the totals.
   logic [CoordBits-1:0] track_x [TableDepth];
   logic [CoordBits-1:0] track_y [TableDepth];
   logic                 track_seen [TableDepth];
   logic [SumBits-1:0]   activity_acc;
   logic [CntBits-1:0]   object_acc;
   logic [CntBits-1:0]   frame_acc;

   report_type  pending_reports [$];
   summary_type expected_summaries [$];
   logic        hold_sender = 1'b0;
   int          error_count = 0;
   int          watchdog = 0;
   int          reports_sent = 0;
   int          results_seen = 0;
   int          repeat_steps = 0;
   int          valid_averages = 0;

   // Stall as seen at the last rising edge, so the driver knows whether its item was taken.
   logic req_stall_seen = 1'b1;
   int   recv_gap = 0;

   initial begin
      forever #4 clock = ~clock;
   end

   // Square root of a squared distance, scaled by the fraction bits and truncated, worked
   // out digit by digit as the hardware does.
   function automatic logic [StepBits-1:0] scaled_root(input logic [63:0] dist_sq);
      logic [63:0] radicand;
      logic [63:0] remainder;
      logic [63:0] root;
      logic [63:0] trial;
      radicand = dist_sq << (2 * FracBits);
      remainder = '0;
      root = '0;
      for (int i = RootBits - 1; i >= 0; i--) begin
         remainder = (remainder << 2) | ((radicand >> (2 * i)) & 64'd3);
         trial = (root << 2) | 64'd1;
         if (remainder >= trial) begin
            remainder = remainder - trial;
            root = (root << 1) | 64'd1;
         end else begin
            root = root << 1;
         end
      end
      return root[StepBits-1:0];
   endfunction

   // Applies one accepted transfer to the predicted state and returns the expected result.
   function automatic summary_type track_motion(input report_type rep);
      summary_type res;
      logic [63:0] dx;
      logic [63:0] dy;
      logic [63:0] quotient;
      logic [IdxBits-1:0] idx;
      res = '0;
      idx = rep.object_id;
      case (rep.kind)
         KIND_REPORT: begin
            if (track_seen[idx]) begin
               dx = rep.pos_x >= track_x[idx] ? rep.pos_x - track_x[idx]
                                              : track_x[idx] - rep.pos_x;
               dy = rep.pos_y >= track_y[idx] ? rep.pos_y - track_y[idx]
                                              : track_y[idx] - rep.pos_y;
               res.step_distance = scaled_root(dx * dx + dy * dy);
               if ({16'd0, res.step_distance} > {16'd0, SumMax} - {16'd0, activity_acc})
                  activity_acc = SumMax;
               else
                  activity_acc = activity_acc + res.step_distance;
            end else begin
               res.first_sighting = 1'b1;
               track_seen[idx] = 1'b1;
            end
            track_x[idx] = rep.pos_x;
            track_y[idx] = rep.pos_y;
         end
         KIND_OBJECT: begin
            if (object_acc != CntMax) object_acc++;
         end
         KIND_FRAME: begin
            if (frame_acc != CntMax) frame_acc++;
         end
         default: begin
            foreach (track_seen[i]) track_seen[i] = 1'b0;
            activity_acc = '0;
            object_acc = '0;
            frame_acc = '0;
         end
      endcase
      if (frame_acc != 0) begin
         quotient = object_acc / frame_acc;
         if (quotient != 0) begin
            res.average_activity = activity_acc / quotient;
            res.average_valid = 1'b1;
         end
      end
      res.activity_total = activity_acc;
      res.object_total = object_acc;
      res.frame_total = frame_acc;
      return res;
   endfunction

   // Mostly short gaps, with the occasional long one and many cycles with none at all.
   function automatic int gap_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic report_type make_report(input kind_type kind, input int id,
                                              input int x, input int y);
      report_type rep;
      rep.kind = kind;
      rep.object_id = IdBits'(id);
      rep.pos_x = CoordBits'(x);
      rep.pos_y = CoordBits'(y);
      return rep;
   endfunction

   // Driver: presents the oldest pending item and drops valid during a gap, a hold-off or when none is left.
   int send_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall_seen) begin
            // The previous transfer was taken at the last rising edge.
            send_gap = gap_length();
         end
         if (req_valid && req_stall_seen) begin
            // Hold the payload steady while the block stalls.
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_reports.size() != 0 && !hold_sender) begin
            req_valid <= 1'b1;
            req_kind <= pending_reports[0].kind;
            req_object_id <= pending_reports[0].object_id;
            req_pos_x <= pending_reports[0].pos_x;
            req_pos_y <= pending_reports[0].pos_y;
            void'(pending_reports.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: predicts each accepted input and checks each accepted result.
   always @(posedge clock) begin
      summary_type want;
      req_stall_seen <= req_stall;
      if (reset) begin
         watchdog <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_summaries.push_back(track_motion(make_report(kind_type'(req_kind),
               req_object_id, req_pos_x, req_pos_y)));
            reports_sent++;
         end
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (expected_summaries.size() == 0) begin
               $error("result with no expectation waiting");
               error_count++;
            end else begin
               want = expected_summaries.pop_front();
               if (want.step_distance != rsp_step_distance) begin
                  $error("step_distance: expected %0d, got %0d", want.step_distance,
                         rsp_step_distance);
                  error_count++;
               end
               if (want.first_sighting != rsp_first_sighting) begin
                  $error("first_sighting: expected %0d, got %0d", want.first_sighting,
                         rsp_first_sighting);
                  error_count++;
               end
               if (want.activity_total != rsp_activity_total) begin
                  $error("activity_total: expected %0d, got %0d", want.activity_total,
                         rsp_activity_total);
                  error_count++;
               end
               if (want.object_total != rsp_object_total) begin
                  $error("object_total: expected %0d, got %0d", want.object_total,
                         rsp_object_total);
                  error_count++;
               end
               if (want.frame_total != rsp_frame_total) begin
                  $error("frame_total: expected %0d, got %0d", want.frame_total,
                         rsp_frame_total);
                  error_count++;
               end
               if (want.average_activity != rsp_average_activity) begin
                  $error("average_activity: expected %0d, got %0d", want.average_activity,
                         rsp_average_activity);
                  error_count++;
               end
               if (want.average_valid != rsp_average_valid) begin
                  $error("average_valid: expected %0d, got %0d", want.average_valid,
                         rsp_average_valid);
                  error_count++;
               end
               if (want.first_sighting == 1'b0 && want.step_distance != 0) repeat_steps++;
               if (want.average_valid) valid_averages++;
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) watchdog <= 0;
         else watchdog <= watchdog + 1;
      end
   end

   // Receiver stalls are drawn from the same gap shape, changed at the falling edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            // A result is on offer; maybe hold it off for a while.
            recv_gap = gap_length();
            rsp_stall <= (recv_gap > 0);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      int id;
      foreach (track_seen[i]) begin
         track_seen[i] = 1'b0;
         track_x[i] = '0;
         track_y[i] = '0;
      end
      activity_acc = '0;
      object_acc = '0;
      frame_acc = '0;

      // Directed part: first sightings, coordinate extremes, every kind and clear.
      pending_reports.push_back(make_report(KIND_REPORT, 0, 0, 0));
      pending_reports.push_back(make_report(KIND_REPORT, 0, 4095, 4095));
      pending_reports.push_back(make_report(KIND_REPORT, 0, 0, 4095));
      pending_reports.push_back(make_report(KIND_REPORT, 1023, 4095, 0));
      pending_reports.push_back(make_report(KIND_REPORT, 1023, 0, 4095));
      pending_reports.push_back(make_report(KIND_REPORT, 1023, 0, 4095));
      pending_reports.push_back(make_report(KIND_REPORT, 1023, 3, 4));
      // Frame with no objects gives a zero quotient, then objects make it valid.
      pending_reports.push_back(make_report(KIND_FRAME, 0, 0, 0));
      pending_reports.push_back(make_report(KIND_OBJECT, 1023, 4095, 4095));
      pending_reports.push_back(make_report(KIND_OBJECT, 512, 1, 2));
      pending_reports.push_back(make_report(KIND_FRAME, 0, 0, 0));
      pending_reports.push_back(make_report(KIND_REPORT, 0, 1, 1));
      pending_reports.push_back(make_report(KIND_CLEAR, 1023, 4095, 4095));
      pending_reports.push_back(make_report(KIND_REPORT, 0, 7, 7));
      pending_reports.push_back(make_report(KIND_OBJECT, 0, 0, 0));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Random part: reports on a small set of ids so most are repeats, mixed with counts.
      for (int n = 0; n < 1000; n++) begin
         int roll;
         roll = $urandom_range(0, 99);
         id = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
         if (roll < 65)
            pending_reports.push_back(make_report(KIND_REPORT, id,
               $urandom_range(0, 4095), $urandom_range(0, 4095)));
         else if (roll < 82)
            pending_reports.push_back(make_report(KIND_OBJECT, $urandom, $urandom, $urandom));
         else if (roll < 98)
            pending_reports.push_back(make_report(KIND_FRAME, $urandom, $urandom, $urandom));
         else
            pending_reports.push_back(make_report(KIND_CLEAR, $urandom, $urandom, $urandom));
         if (n == 500) begin
            // The generator waits here until at most one item is pending and no request is presented.
            while (pending_reports.size() > 1 || req_valid) @(posedge clock);
         end
      end
   end

   // One hold-off mid-run: stop the sender until the block has drained.
   initial begin
      wait (reports_sent >= 400);
      @(negedge clock);
      hold_sender <= 1'b1;
      wait (expected_summaries.size() == 0 && !req_valid);
      @(negedge clock);
      hold_sender <= 1'b0;
   end

   // Finish once everything has drained, or on the watchdog.
   initial begin
      wait (!reset);
      forever begin
         @(posedge clock);
         if (watchdog >= WatchdogLimit) begin
            $display("FAILED: results differ");
            $finish;
         end
         if (reports_sent >= 1015 && pending_reports.size() == 0 && !req_valid
             && expected_summaries.size() == 0) begin
            repeat (200) @(posedge clock);
            $display("Run covered %0d transfers, %0d repeat-id steps, %0d valid averages.",
                     results_seen, repeat_steps, valid_averages);
            if (error_count == 0 && expected_summaries.size() == 0)
               $display("PASSED: all results match");
            else
               $display("FAILED: results differ");
            $finish;
         end
      end
   end
endmodule
`default_nettype wire

/* filelist.f */
sv/omaa_pkg.sv
sv/omaa_ram.sv
sv/omaa_div.sv
sv/object_motion_activity_accumulator.sv
test/object_motion_activity_accumulator_tb.sv
